// ===== src/pls_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the PCM link statistics block.
// Depends on nothing; every other file in src imports it.
package pls_pkg;

	localparam int MAX_PACKET_BYTES = 1024;
	localparam int LEN_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int MTU_W = 11;
	localparam int CMP_W = (LEN_W > MTU_W) ? LEN_W : MTU_W;
	localparam int SQ_W = 63;
	localparam int PROD_W = 32;
	localparam int CNT_W = 32;
	localparam int DIST_W = 9;

	localparam logic [MTU_W-1:0] MTU_DEFAULT = MTU_W'(48);
	localparam logic [SQ_W-1:0] SQ_LIMIT = {SQ_W{1'b1}};
	localparam logic [DIST_W-1:0] SILENCE_MAX = DIST_W'(2);
	localparam logic signed [15:0] SAMPLE_POS_LIMIT = 16'sh7fff;
	localparam logic signed [15:0] SAMPLE_NEG_LIMIT = 16'sh8000;

	// Running totals as they stand after the byte that ends a packet.
	typedef struct packed {
		logic [CNT_W-1:0] packet_total;
		logic [CNT_W-1:0] byte_total;
		logic [CNT_W-1:0] short_packet_total;
		logic [DIST_W-1:0] distinct_values;
		logic signed [15:0] sample_min;
		logic signed [15:0] sample_max;
		logic [CNT_W-1:0] sample_total;
	} pls_totals_t;

	// Per-byte information handed to the square accumulator.
	typedef struct packed {
		logic last;
		logic sq_vld;
		logic [PROD_W-1:0] square;
	} pls_sq_t;

endpackage

// ===== src/pls_byte_stage.sv =====
`timescale 1ns / 1ps
// Byte stage: value map, distinct count, packet and byte counters, sample
// assembly, min/max and the sample square. Depends on pls_pkg.
module pls_byte_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      stall,
	input  logic                      valid_s1,
	input  logic [7:0]                data_s1,
	input  logic                      last_s1,
	input  logic [pls_pkg::MTU_W-1:0] mtu_q,
	output logic                      valid_s2,
	output pls_pkg::pls_sq_t          sq_s2,
	output pls_pkg::pls_totals_t      totals_s2
);
	import pls_pkg::*;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + CNT_W'(1);
	endfunction

	logic [255:0]             seen_q;
	logic [DIST_W-1:0]        distinct_q;
	logic                     half_q;
	logic [7:0]               low_q;
	logic [LEN_W-1:0]         len_q;
	logic [CNT_W-1:0]         pkt_q;
	logic [CNT_W-1:0]         byte_q;
	logic [CNT_W-1:0]         short_q;
	logic [CNT_W-1:0]         samp_q;
	logic signed [15:0]       min_q;
	logic signed [15:0]       max_q;

	logic                     fire;
	logic                     in_pkt;
	logic                     take;
	logic signed [15:0]       sample;
	logic signed [PROD_W-1:0] product;
	logic [LEN_W-1:0]         len_nx;
	logic [MTU_W-1:0]         mtu_eff;
	logic                     is_short;
	pls_totals_t              nx;

	always_comb begin
		fire = valid_s1 & ~stall;
		// Bytes past the length limit are dropped, but a marked one still ends the packet.
		in_pkt = len_q < LEN_W'(MAX_PACKET_BYTES);
		take = in_pkt & half_q;
		sample = signed'({data_s1, low_q});
		product = sample * sample;
		len_nx = in_pkt ? len_q + LEN_W'(1) : len_q;
		if (mtu_q == '0 || CMP_W'(mtu_q) > CMP_W'(MAX_PACKET_BYTES)) begin
			mtu_eff = MTU_DEFAULT;
		end else begin
			mtu_eff = mtu_q;
		end
		is_short = CMP_W'(len_nx) < CMP_W'(mtu_eff);

		nx.packet_total = last_s1 ? sat_inc(pkt_q) : pkt_q;
		nx.byte_total = in_pkt ? sat_inc(byte_q) : byte_q;
		nx.short_packet_total = (last_s1 && is_short) ? sat_inc(short_q) : short_q;
		nx.distinct_values = (in_pkt && !seen_q[data_s1]) ? distinct_q + DIST_W'(1)
			: distinct_q;
		nx.sample_min = (take && sample < min_q) ? sample : min_q;
		nx.sample_max = (take && sample > max_q) ? sample : max_q;
		nx.sample_total = take ? sat_inc(samp_q) : samp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			distinct_q <= '0;
			half_q <= 1'b0;
			low_q <= '0;
			len_q <= '0;
			pkt_q <= '0;
			byte_q <= '0;
			short_q <= '0;
			samp_q <= '0;
			min_q <= SAMPLE_POS_LIMIT;
			max_q <= SAMPLE_NEG_LIMIT;
			valid_s2 <= 1'b0;
		end else begin
			if (!stall) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				if (in_pkt) begin
					seen_q[data_s1] <= 1'b1;
				end
				if (in_pkt && !half_q) begin
					low_q <= data_s1;
				end
				distinct_q <= nx.distinct_values;
				pkt_q <= nx.packet_total;
				byte_q <= nx.byte_total;
				short_q <= nx.short_packet_total;
				samp_q <= nx.sample_total;
				min_q <= nx.sample_min;
				max_q <= nx.sample_max;
				// A packet end clears the length and drops a pending half sample.
				if (last_s1) begin
					len_q <= '0;
					half_q <= 1'b0;
				end else begin
					len_q <= len_nx;
					half_q <= in_pkt ? ~half_q : half_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sq_s2.last <= last_s1;
			sq_s2.sq_vld <= take;
			sq_s2.square <= unsigned'(product);
			if (last_s1) begin
				totals_s2 <= nx;
			end
		end
	end

`ifndef SYNTH
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_PACKET_BYTES))
		else $error("packet length count beyond limit");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> (!half_q && len_q == '0))
		else $error("packet end did not clear length or half sample");

	a_distinct_map: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(seen_q) == 32'(distinct_q))
		else $error("distinct count disagrees with value map");
`endif

endmodule

// ===== src/pls_accum_stage.sv =====
`timescale 1ns / 1ps
// Accumulate stage: saturating sum of squares and the result register.
// Depends on pls_pkg.
module pls_accum_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          stall,
	input  logic                          valid_s2,
	input  pls_pkg::pls_sq_t              sq_s2,
	input  pls_pkg::pls_totals_t          totals_s2,
	input  logic                          out_ready,
	output logic                          out_valid,
	output pls_pkg::pls_totals_t          totals_q,
	output logic [pls_pkg::SQ_W-1:0]      square_q,
	output logic                          silence_q
);
	import pls_pkg::*;

	logic [SQ_W-1:0] acc_q;
	logic [SQ_W-1:0] acc_nx;
	logic [SQ_W:0]   sum;
	logic            fire;

	always_comb begin
		fire = valid_s2 & ~stall;
		// The accumulator never exceeds the limit, so a carry out of the
		// low bits is exactly the overflow condition.
		sum = {1'b0, acc_q} + (SQ_W + 1)'(sq_s2.square);
		if (fire && sq_s2.sq_vld) begin
			acc_nx = sum[SQ_W] ? SQ_LIMIT : sum[SQ_W-1:0];
		end else begin
			acc_nx = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			out_valid <= 1'b0;
		end else begin
			acc_q <= acc_nx;
			if (fire && sq_s2.last) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && sq_s2.last) begin
			totals_q <= totals_s2;
			square_q <= acc_nx;
			silence_q <= totals_s2.distinct_values <= SILENCE_MAX;
		end
	end

`ifndef SYNTH
	a_acc_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q >= $past(acc_q))
		else $error("square sum decreased");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s2 && sq_s2.last && !stall))
		else $error("result raised without a packet end");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> (out_valid && !out_ready))
		else $error("pipeline stalled with a free result register");
`endif

endmodule

// ===== src/pcm_link_statistics.sv =====
`timescale 1ns / 1ps
// Running statistics over a received link byte stream.
// Input channel: data_byte plus last_byte, one byte per transfer (valid/ready).
// Config channel: mtu_bytes write with cfg_valid/cfg_ready, always ready.
// Output channel: one result transfer for every byte marked last_byte.
// A result passes through the input register, the byte stage and the result
// register after the transfer of its last byte.
// Throughput: one byte per cycle when not stalled, set by the single-pass byte
// stage; the value map is a 256-bit register read and written in the same cycle.
// Reset clears every counter and the value map, presets the sample extremes,
// sets the MTU to 48. An MTU of 0 or above the packet length limit acts as 48.
// When a result waits in the output register and the next packet end reaches
// the accumulate stage, the whole pipeline holds and in_ready goes low until
// the waiting result is taken. Other bytes keep flowing while a result waits.
// Depends on pls_pkg, pls_byte_stage and pls_accum_stage.
module pcm_link_statistics (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                data_byte,
	input  logic                      last_byte,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [pls_pkg::MTU_W-1:0] mtu_bytes,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [31:0]               packet_total,
	output logic [31:0]               byte_total,
	output logic [31:0]               short_packet_total,
	output logic [8:0]                distinct_values,
	output logic signed [15:0]        sample_min,
	output logic signed [15:0]        sample_max,
	output logic [62:0]               square_total,
	output logic [31:0]               sample_total,
	output logic                      silence_flag
);
	import pls_pkg::*;

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             last_s1;
	logic [MTU_W-1:0] mtu_q;
	logic             stall;
	logic             valid_s2;
	pls_sq_t          sq_s2;
	pls_totals_t      totals_s2;
	pls_totals_t      totals_q;
	logic [SQ_W-1:0]  square_q;
	logic             silence_q;

	// Only a packet end meeting an occupied result register holds things up.
	assign stall = valid_s2 & sq_s2.last & out_valid & ~out_ready;
	assign in_ready = ~stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mtu_q <= MTU_DEFAULT;
		end else begin
			if (!stall) begin
				valid_s1 <= in_valid;
			end
			if (cfg_valid) begin
				mtu_q <= mtu_bytes;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	pls_byte_stage u_byte (
		.clk       (clk),
		.arst_n    (arst_n),
		.stall     (stall),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1),
		.last_s1   (last_s1),
		.mtu_q     (mtu_q),
		.valid_s2  (valid_s2),
		.sq_s2     (sq_s2),
		.totals_s2 (totals_s2)
	);

	pls_accum_stage u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.stall     (stall),
		.valid_s2  (valid_s2),
		.sq_s2     (sq_s2),
		.totals_s2 (totals_s2),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.totals_q  (totals_q),
		.square_q  (square_q),
		.silence_q (silence_q)
	);

	assign packet_total = totals_q.packet_total;
	assign byte_total = totals_q.byte_total;
	assign short_packet_total = totals_q.short_packet_total;
	assign distinct_values = totals_q.distinct_values;
	assign sample_min = totals_q.sample_min;
	assign sample_max = totals_q.sample_max;
	assign sample_total = totals_q.sample_total;
	assign square_total = square_q;
	assign silence_flag = silence_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pcm_link_statistics: drives link bytes and MTU writes,
// predicts every packet-end report and compares it field by field.
// Depends on pls_pkg and the pcm_link_statistics RTL in src.
module tb;

	import pls_pkg::*;

	typedef struct {
		logic [31:0]        packets;
		logic [31:0]        bytes;
		logic [31:0]        shorts;
		logic [8:0]         distinct;
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic [62:0]        squares;
		logic [31:0]        samples;
		logic               silence;
	} link_totals_t;

	// Tracks the link statistics as the block should, and holds the reports
	// still owed by the block.
	class link_stats_board;
		link_totals_t       owed_q[$];
		int                 errors;
		logic [255:0]       seen;
		logic [8:0]         n_distinct;
		logic               half;
		logic [7:0]         low_hold;
		int                 pkt_len;
		logic [31:0]        n_packets;
		logic [31:0]        n_bytes;
		logic [31:0]        n_shorts;
		logic signed [15:0] run_lo;
		logic signed [15:0] run_hi;
		logic [62:0]        sq_sum;
		logic [31:0]        n_samples;
		logic [10:0]        mtu;

		function new();
			errors = 0;
			seen = '0;
			n_distinct = '0;
			half = 1'b0;
			low_hold = '0;
			pkt_len = 0;
			n_packets = '0;
			n_bytes = '0;
			n_shorts = '0;
			run_lo = SAMPLE_POS_LIMIT;
			run_hi = SAMPLE_NEG_LIMIT;
			sq_sum = '0;
			n_samples = '0;
			mtu = MTU_DEFAULT;
		endfunction

		function logic [31:0] bump(logic [31:0] v);
			return (v == '1) ? v : v + 32'd1;
		endfunction

		function void set_mtu(logic [10:0] v);
			mtu = v;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			link_totals_t t;
			logic signed [15:0] s;
			longint wide;
			logic [62:0] sq;
			int eff;
			// Bytes past the packet length limit are dropped, but a marked one still ends it.
			if (pkt_len < MAX_PACKET_BYTES) begin
				pkt_len++;
				n_bytes = bump(n_bytes);
				if (!seen[b]) begin
					seen[b] = 1'b1;
					n_distinct++;
				end
				if (half) begin
					s = {b, low_hold};
					if (s < run_lo)
						run_lo = s;
					if (s > run_hi)
						run_hi = s;
					wide = s;
					sq = 63'(wide * wide);
					sq_sum = (sq_sum > SQ_LIMIT - sq) ? SQ_LIMIT : sq_sum + sq;
					n_samples = bump(n_samples);
					half = 1'b0;
				end else begin
					low_hold = b;
					half = 1'b1;
				end
			end
			if (!last)
				return;
			eff = (mtu == 0 || mtu > MAX_PACKET_BYTES) ? int'(MTU_DEFAULT) : int'(mtu);
			n_packets = bump(n_packets);
			if (pkt_len < eff)
				n_shorts = bump(n_shorts);
			pkt_len = 0;
			half = 1'b0;
			t.packets = n_packets;
			t.bytes = n_bytes;
			t.shorts = n_shorts;
			t.distinct = n_distinct;
			t.lo = run_lo;
			t.hi = run_hi;
			t.squares = sq_sum;
			t.samples = n_samples;
			t.silence = (n_distinct <= SILENCE_MAX);
			owed_q.push_back(t);
		endfunction

		function void cmp(string field, longint want, longint got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, actual %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_totals(link_totals_t got);
			link_totals_t want;
			if (owed_q.size() == 0) begin
				$error("report with no packet end pending: packet_total %0d", got.packets);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			cmp("packet_total", want.packets, got.packets);
			cmp("byte_total", want.bytes, got.bytes);
			cmp("short_packet_total", want.shorts, got.shorts);
			cmp("distinct_values", want.distinct, got.distinct);
			cmp("sample_min", longint'(want.lo), longint'(got.lo));
			cmp("sample_max", longint'(want.hi), longint'(got.hi));
			cmp("square_total", want.squares, got.squares);
			cmp("sample_total", want.samples, got.samples);
			cmp("silence_flag", want.silence, got.silence);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         data_byte = '0;
	logic               last_byte = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [10:0]        mtu_bytes = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [31:0]        packet_total;
	logic [31:0]        byte_total;
	logic [31:0]        short_packet_total;
	logic [8:0]         distinct_values;
	logic signed [15:0] sample_min;
	logic signed [15:0] sample_max;
	logic [62:0]        square_total;
	logic [31:0]        sample_total;
	logic               silence_flag;

	link_stats_board board = new();
	bit  calm = 1'b0;
	int  results_seen = 0;
	int  hold_at = -1;
	int  hold_left = 0;

	pcm_link_statistics u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.data_byte          (data_byte),
		.last_byte          (last_byte),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.mtu_bytes          (mtu_bytes),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.packet_total       (packet_total),
		.byte_total         (byte_total),
		.short_packet_total (short_packet_total),
		.distinct_values    (distinct_values),
		.sample_min         (sample_min),
		.sample_max         (sample_max),
		.square_total       (square_total),
		.sample_total       (sample_total),
		.silence_flag       (silence_flag)
	);

	always #5 clk = ~clk;

	// Result side: check each transfer, then pick the next ready value. One long
	// hold-off starts once the burst phase has produced a few reports.
	always @(posedge clk) begin
		link_totals_t got;
		if (out_valid && out_ready) begin
			got.packets = packet_total;
			got.bytes = byte_total;
			got.shorts = short_packet_total;
			got.distinct = distinct_values;
			got.lo = sample_min;
			got.hi = sample_max;
			got.squares = square_total;
			got.samples = sample_total;
			got.silence = silence_flag;
			board.check_totals(got);
			results_seen++;
			if (results_seen == hold_at)
				hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= 12);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!calm && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_byte(b, last);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'h80;
			3: return 8'h7f;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_packet(input int len);
		for (int i = 0; i < len; i++)
			send_byte(pick_byte(), i == len - 1);
	endtask

	// Let every owed report arrive, then give the pipeline a few more cycles.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mtu(input logic [10:0] v);
		cfg_valid <= 1'b1;
		mtu_bytes <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_mtu(v);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [8:0] opening[$];
		int settings[8];
		int v;
		int eff;
		int len;
		int sent;

		// Each entry is {last_byte, data_byte}.
		opening = '{
			9'h100,                         // one-byte packet, no sample
			9'h0ff, 9'h1ff,                 // minus one
			9'h000, 9'h0ff, 9'h100,         // odd trailing byte is dropped
			9'h000, 9'h180,                 // most negative sample
			9'h0ff, 9'h17f,                 // most positive sample
			9'h001, 9'h000, 9'h0fe, 9'h1ff,
			9'h055, 9'h0aa, 9'h13c
		};
		settings = '{1, 2047, 16, 0, 60, 1025, 0, 48};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			send_byte(opening[i][7:0], opening[i][8]);

		for (int p = 0; p < 8; p++) begin
			wait_idle();
			v = (p == 6) ? $urandom_range(2, 64) : settings[p];
			write_mtu(11'(v));
			eff = (v == 0 || v > MAX_PACKET_BYTES) ? int'(MTU_DEFAULT) : v;
			calm = (p == 2);
			if (p == 4)
				hold_at = results_seen + 3;
			sent = 0;
			while (sent < 30) begin
				if (p == 4)
					len = $urandom_range(1, 3);
				else if ($urandom_range(0, 3) == 0)
					len = eff - 1 + $urandom_range(0, 2);
				else
					len = $urandom_range(1, 40);
				if (len < 1)
					len = 1;
				if (len > 80)
					len = 80;
				send_packet(len);
				sent += len;
			end
		end

		// Largest MTU: a short packet, then one a byte past the length limit
		// whose marked byte is itself dropped.
		wait_idle();
		calm = 1'b0;
		write_mtu(11'(MAX_PACKET_BYTES));
		send_packet(10);
		send_packet(MAX_PACKET_BYTES + 1);

		wait_idle();
		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
